// ===== rtl/rawip_pkg.sv =====
// shared types and constants of the rate-aware worker id pool
`default_nettype none
package rawip_pkg;

    localparam int unsigned POOL_DEPTH   = 64;
    localparam int unsigned ID_BITS      = 8;
    localparam int unsigned WINDOW_DEPTH = 64;
    localparam int unsigned POOL_AW      = $clog2(POOL_DEPTH);
    localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned SLOT_W       = 16;
    localparam int unsigned TOT_W        = 22;
    localparam int unsigned PROD_W       = 38;
    localparam int unsigned DIVD_W       = PROD_W - 8;
    localparam int unsigned DIVS_W       = TOT_W;
    localparam int unsigned CFG_W        = 16;

    // operation codes
    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_REQ_BATCH = 3'd1;
    localparam logic [2:0] OP_REL_BATCH = 3'd2;
    localparam logic [2:0] OP_REQ_NODE  = 3'd3;
    localparam logic [2:0] OP_REL_NODE  = 3'd4;
    localparam logic [2:0] OP_TICK      = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_STATIC_GAIN = 3'd0;
    localparam logic [2:0] CFG_SWITCH_THR  = 3'd1;
    localparam logic [2:0] CFG_WIN_M1      = 3'd2;
    localparam logic [2:0] CFG_RATE_GAIN   = 3'd3;
    localparam logic [2:0] CFG_NODE_RATIO  = 3'd4;
    localparam logic [2:0] CFG_NODE_CAP    = 3'd5;
    localparam logic [2:0] CFG_BATCH_MAX   = 3'd6;
    localparam logic [2:0] CFG_BATCH_MIN   = 3'd7;

    typedef struct packed {
        logic [2:0]         operation;
        logic [ID_BITS-1:0] worker_id;
        logic [CNT_W-1:0]   wanted;
    } t_item;

    typedef struct packed {
        logic [ID_BITS-1:0] granted_id;
        logic               id_valid;
        logic [CNT_W-1:0]   grant_count;
        logic               last;
        logic               fault;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] addr;
        logic [SLOT_W-1:0] req;
        logic [SLOT_W-1:0] rel;
    } t_slot_wr;

endpackage
`default_nettype wire

// ===== rtl/rawip_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module rawip_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rawip_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [rawip_pkg::DIVS_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [rawip_pkg::DIVD_W-1:0]       o_quotient
);
    localparam int unsigned DW = rawip_pkg::DIVD_W;
    localparam int unsigned SW = rawip_pkg::DIVS_W;
    localparam int unsigned SC_W = $clog2(DW);

    logic          r_run, n_run;
    logic          r_done, n_done;
    logic [SC_W-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_rem, n_rem;
    logic [SW-1:0] r_dvs, n_dvs;
    logic [SW:0]   shifted;
    logic [SW+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_run) begin
            n_rem = diff[SW+1] ? shifted[SW-1:0] : diff[SW-1:0];
            n_quo = {r_quo[DW-2:0], ~diff[SW+1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SC_W'(DW - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ===== rtl/rawip_slot_mem.sv =====
// per-second request and release slot memory with per-entry valid bits
`default_nettype none
module rawip_slot_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rawip_pkg::t_slot_wr           i_wr,
    input  wire logic                          i_re,
    input  wire logic [rawip_pkg::WIN_AW-1:0]  i_raddr,
    output logic [rawip_pkg::SLOT_W-1:0]       o_req,
    output logic [rawip_pkg::SLOT_W-1:0]       o_rel
);
    localparam int unsigned DEPTH = rawip_pkg::WINDOW_DEPTH;
    localparam int unsigned SW    = rawip_pkg::SLOT_W;

    logic [2*SW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [2*SW-1:0] r_q;
    logic            r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= {i_wr.req, i_wr.rel};
        end
        if (i_re) begin
            r_q  <= r_mem[i_raddr];
            r_qv <= r_valid[i_raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_req = r_qv ? r_q[2*SW-1:SW] : '0;
    assign o_rel = r_qv ? r_q[SW-1:0]    : '0;
endmodule
`default_nettype wire

// ===== rtl/rate_aware_worker_id_pool_unit.sv =====
// top level of the rate-aware worker id pool: sequencer, id stack memory, window totals
//
// channel   direction  handshake                    payload
// command   in         i_start, o_busy              i_item (operation, worker_id, wanted)
// result    out        o_res_valid (one cycle)      o_res (granted_id .. fault)
// config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// add runs S_ADD; node request runs S_NODE_RD and, if it grants an id, S_NODE_OUT;
// releases run S_CNT_RD and S_CNT_WR; a started tick runs S_TICK_A to S_TICK_C
// a batch request runs S_CNT_RD, S_CNT_WR, S_BATCH, S_DIV_GO and S_DIV_WAIT when it
// divides (30 divider steps), then S_CLAMP and S_EMIT, one result per id granted
// config is taken only while idle with no item offered
// reset is synchronous, active low; the slot memory comes up cleared through valid bits
// results cannot be stalled: each is shown for exactly one cycle
`default_nettype none
module rate_aware_worker_id_pool_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire rawip_pkg::t_item               i_item,
    output logic                                o_busy,
    output logic                                o_res_valid,
    output rawip_pkg::t_result                  o_res,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [rawip_pkg::CFG_W-1:0]    i_cfg_data
);
    localparam int unsigned CW  = rawip_pkg::CNT_W;
    localparam int unsigned TW  = rawip_pkg::TOT_W;
    localparam int unsigned SW  = rawip_pkg::SLOT_W;
    localparam int unsigned PW  = rawip_pkg::PROD_W;
    localparam int unsigned PA  = rawip_pkg::POOL_AW;
    localparam int unsigned WA  = rawip_pkg::WIN_AW;
    localparam int unsigned IDW = rawip_pkg::ID_BITS;
    localparam int unsigned DW  = rawip_pkg::DIVD_W;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_ADD      = 15'b000000000000010,
        S_CNT_RD   = 15'b000000000000100,
        S_CNT_WR   = 15'b000000000001000,
        S_BATCH    = 15'b000000000010000,
        S_DIV_GO   = 15'b000000000100000,
        S_DIV_WAIT = 15'b000000001000000,
        S_CLAMP    = 15'b000000010000000,
        S_EMIT     = 15'b000000100000000,
        S_NODE_RD  = 15'b000001000000000,
        S_NODE_OUT = 15'b000010000000000,
        S_TICK_A   = 15'b000100000000000,
        S_TICK_B   = 15'b001000000000000,
        S_TICK_C   = 15'b010000000000000,
        S_FIN      = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0]   r_static_gain, n_static_gain;
    logic [8:0]    r_switch_thr, n_switch_thr;
    logic [5:0]    r_win_m1, n_win_m1;
    logic [15:0]   r_rate_gain, n_rate_gain;
    logic [8:0]    r_node_ratio, n_node_ratio;
    logic [CW-1:0] r_node_cap, n_node_cap;
    logic [CW-1:0] r_batch_max, n_batch_max;
    logic [CW-1:0] r_batch_min, n_batch_min;

    // pool and window state
    logic [CW-1:0] r_free_count, n_free_count;
    logic [CW-1:0] r_total_ids, n_total_ids;
    logic [CW-1:0] r_nio, n_nio;
    logic [CW-1:0] r_node_limit, n_node_limit;
    logic [TW-1:0] r_req_total, n_req_total;
    logic [TW-1:0] r_rel_total, n_rel_total;
    logic [WA-1:0] r_slot_ptr, n_slot_ptr;
    logic          r_window_full, n_window_full;
    logic          r_static_mode, n_static_mode;
    logic          r_started, n_started;
    logic          r_time_moved, n_time_moved;

    // per-item working registers
    rawip_pkg::t_item   r_item, n_item;
    logic [PW-1:0]      r_prod, n_prod;
    logic [CW-1:0]      r_m, n_m;
    logic [CW-1:0]      r_size, n_size;
    logic [CW-1:0]      r_k, n_k;
    logic [PA-1:0]      r_base, n_base;
    logic [CW-1:0]      r_idx, n_idx;
    rawip_pkg::t_result r_res, n_res;
    logic               r_res_valid, n_res_valid;

    // id stack memory
    logic [IDW-1:0] r_stack [rawip_pkg::POOL_DEPTH];
    logic [IDW-1:0] r_stk_q;
    logic           stk_we, stk_re;
    logic [PA-1:0]  stk_waddr, stk_raddr;

    // slot memory and divider hookup
    rawip_pkg::t_slot_wr slot_wr;
    logic                slot_re;
    logic [WA-1:0]       slot_raddr;
    logic [SW-1:0]       slot_req, slot_rel;
    logic                div_start, div_done;
    logic [rawip_pkg::DIVD_W-1:0] div_q;
    logic [rawip_pkg::DIVS_W-1:0] div_divisor;

    // helpers
    logic [15:0]        lim_prod;
    logic [7:0]         lim_sh;
    logic [CW-1:0]      lim_cap;
    logic [7:0]         nio2;
    logic [CW-1:0]      m_val;
    logic [SW:0]        sum_req, sum_rel;
    logic               is_req;
    logic signed [10:0] thr_term;
    logic signed [7:0]  occ_term;
    logic signed [18:0] rhs, lhs;
    logic [CW-1:0]      s1, s2, s3, s4, s5;
    logic [CW:0]        tick_p1;
    logic               tick_wrap;
    logic [WA-1:0]      tick_np;
    logic               emit_last;

    rawip_slot_mem u_slot_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (slot_wr),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_req   (slot_req),
        .o_rel   (slot_rel)
    );

    rawip_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[PW-1:8]),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // stack memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= r_item.worker_id;
        end
        if (stk_re) begin
            r_stk_q <= r_stack[stk_raddr];
        end
    end

    // node limit follows ratio, cap and total ids
    always_comb begin
        lim_prod     = 16'(r_node_ratio) * 16'(r_total_ids);
        lim_sh       = lim_prod[15:8];
        lim_cap      = (lim_sh > {1'b0, r_node_cap}) ? r_node_cap : lim_sh[CW-1:0];
        n_node_limit = (lim_cap == '0) ? CW'(1) : lim_cap;
    end

    // divisor: node share in static mode, request total in rate mode
    assign div_divisor = r_static_mode ? {{(rawip_pkg::DIVS_W-CW){1'b0}}, r_m} : r_req_total;

    always_comb begin
        // batch split: m = min(2 * node ids out, node limit)
        nio2  = {r_nio, 1'b0};
        m_val = (nio2 > {1'b0, r_node_limit}) ? r_node_limit : nio2[CW-1:0];

        // counted event: saturating slot update
        is_req  = (r_item.operation == rawip_pkg::OP_REQ_BATCH);
        sum_req = {1'b0, slot_req} + {{SW{1'b0}}, is_req};
        sum_rel = {1'b0, slot_rel} + {{SW{1'b0}}, ~is_req};

        // mode decision, signed compare
        thr_term = 11'sd256 - $signed({2'b00, r_switch_thr});
        occ_term = $signed({1'b0, r_total_ids}) - $signed({1'b0, r_nio});
        rhs      = thr_term * occ_term;
        lhs      = $signed({4'b0000, r_free_count, 8'h00});

        // batch size rules
        s1 = (r_item.wanted >= r_batch_min && r_size < r_batch_min) ? '0 : r_size;
        s2 = (s1 > r_batch_max) ? r_batch_max : s1;
        s3 = (s2 != '0 && !s2[0]) ? s2 - 1'b1 : s2;
        s4 = (s3 > r_item.wanted) ? r_item.wanted : s3;
        s5 = (s4 > CW'(rawip_pkg::POOL_DEPTH)) ? CW'(rawip_pkg::POOL_DEPTH) : s4;

        // window advance
        tick_p1   = {1'b0, r_slot_ptr} + 1'b1;
        tick_wrap = (tick_p1 > {1'b0, r_win_m1}) ||
                    (tick_p1 >= (CW)'(rawip_pkg::WINDOW_DEPTH));
        tick_np   = tick_wrap ? '0 : tick_p1[WA-1:0];

        emit_last = ((r_idx + 1'b1) == r_k);
    end

    always_comb begin
        n_state       = r_state;
        n_static_gain = r_static_gain;
        n_switch_thr  = r_switch_thr;
        n_win_m1      = r_win_m1;
        n_rate_gain   = r_rate_gain;
        n_node_ratio  = r_node_ratio;
        n_node_cap    = r_node_cap;
        n_batch_max   = r_batch_max;
        n_batch_min   = r_batch_min;
        n_free_count  = r_free_count;
        n_total_ids   = r_total_ids;
        n_nio         = r_nio;
        n_req_total   = r_req_total;
        n_rel_total   = r_rel_total;
        n_slot_ptr    = r_slot_ptr;
        n_window_full = r_window_full;
        n_static_mode = r_static_mode;
        n_started     = r_started;
        n_time_moved  = r_time_moved;
        n_item        = r_item;
        n_prod        = r_prod;
        n_m           = r_m;
        n_size        = r_size;
        n_k           = r_k;
        n_base        = r_base;
        n_idx         = r_idx;
        n_res         = '0;
        n_res_valid   = 1'b0;
        stk_we        = 1'b0;
        stk_re        = 1'b0;
        stk_waddr     = r_free_count[PA-1:0];
        stk_raddr     = r_base;
        slot_wr       = '0;
        slot_re       = 1'b0;
        slot_raddr    = r_slot_ptr;
        div_start     = 1'b0;

        // config writes, taken only while idle
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rawip_pkg::CFG_STATIC_GAIN: n_static_gain = i_cfg_data;
                rawip_pkg::CFG_SWITCH_THR:  n_switch_thr  = i_cfg_data[8:0];
                rawip_pkg::CFG_WIN_M1:      n_win_m1      = i_cfg_data[5:0];
                rawip_pkg::CFG_RATE_GAIN:   n_rate_gain   = i_cfg_data;
                rawip_pkg::CFG_NODE_RATIO:  n_node_ratio  = i_cfg_data[8:0];
                rawip_pkg::CFG_NODE_CAP:    n_node_cap    = i_cfg_data[CW-1:0];
                rawip_pkg::CFG_BATCH_MAX:   n_batch_max   = i_cfg_data[CW-1:0];
                rawip_pkg::CFG_BATCH_MIN:   n_batch_min   = i_cfg_data[CW-1:0];
                default:                    n_batch_min   = r_batch_min;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    unique case (i_item.operation)
                        rawip_pkg::OP_ADD:       n_state = S_ADD;
                        rawip_pkg::OP_REQ_BATCH: n_state = S_CNT_RD;
                        rawip_pkg::OP_REL_BATCH: n_state = S_CNT_RD;
                        rawip_pkg::OP_REL_NODE:  n_state = S_CNT_RD;
                        rawip_pkg::OP_REQ_NODE:  n_state = S_NODE_RD;
                        rawip_pkg::OP_TICK:      n_state = r_started ? S_TICK_A : S_FIN;
                        default:                 n_state = S_FIN;
                    endcase
                end
            end
            S_ADD: begin
                n_res.last  = 1'b1;
                n_res_valid = 1'b1;
                if (r_total_ids == '1 || r_free_count >= CW'(rawip_pkg::POOL_DEPTH)) begin
                    n_res.fault = 1'b1;
                end else begin
                    stk_we       = 1'b1;
                    n_free_count = r_free_count + 1'b1;
                    n_total_ids  = r_total_ids + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_CNT_RD: begin
                slot_re = 1'b1;
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                slot_wr.we   = 1'b1;
                slot_wr.addr = r_slot_ptr;
                if (r_started) begin
                    slot_wr.req = sum_req[SW] ? '1 : sum_req[SW-1:0];
                    slot_wr.rel = sum_rel[SW] ? '1 : sum_rel[SW-1:0];
                end else begin
                    slot_wr.req = {{(SW-1){1'b0}}, is_req};
                    slot_wr.rel = {{(SW-1){1'b0}}, ~is_req};
                end
                n_started = 1'b1;
                // first counted event after a tick picks the mode
                if (r_started && r_time_moved) begin
                    n_time_moved  = 1'b0;
                    n_static_mode = !r_window_full || (lhs >= rhs);
                end
                if (is_req) begin
                    n_state = S_BATCH;
                end else begin
                    n_res.last  = 1'b1;
                    n_res_valid = 1'b1;
                    if (r_free_count >= CW'(rawip_pkg::POOL_DEPTH)) begin
                        n_res.fault = 1'b1;
                    end else begin
                        stk_we       = 1'b1;
                        n_free_count = r_free_count + 1'b1;
                    end
                    if (r_item.operation == rawip_pkg::OP_REL_NODE) begin
                        if (r_nio == '0) begin
                            n_res.fault = 1'b1;
                        end else begin
                            n_nio = r_nio - 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            S_BATCH: begin
                n_m = m_val;
                if (r_static_mode) begin
                    if (m_val == '0) begin
                        n_size  = r_free_count;
                        n_state = S_CLAMP;
                    end else if (r_total_ids < m_val) begin
                        // negative numerator
                        n_size  = '0;
                        n_state = S_CLAMP;
                    end else begin
                        n_prod  = PW'(r_static_gain) * PW'(r_total_ids - m_val);
                        n_state = S_DIV_GO;
                    end
                end else begin
                    if (r_req_total == '0) begin
                        n_size  = r_free_count;
                        n_state = S_CLAMP;
                    end else begin
                        n_prod  = PW'(r_rate_gain) * PW'(r_rel_total);
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_size  = (div_q > DW'(r_free_count)) ?
                              r_free_count : div_q[CW-1:0];
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (s5 == '0) begin
                    n_res.last  = 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_k          = s5;
                    n_idx        = '0;
                    n_base       = PA'(r_free_count - s5);
                    n_free_count = r_free_count - s5;
                    stk_re       = 1'b1;
                    stk_raddr    = PA'(r_free_count - s5);
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                n_res.granted_id  = r_stk_q;
                n_res.id_valid    = 1'b1;
                n_res.grant_count = r_k;
                n_res.last        = emit_last;
                n_res_valid       = 1'b1;
                if (emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    stk_re    = 1'b1;
                    stk_raddr = r_base + PA'(r_idx + 1'b1);
                end
            end
            S_NODE_RD: begin
                if (r_free_count == '0 || r_nio >= r_node_limit) begin
                    n_res.last  = 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    stk_re       = 1'b1;
                    stk_raddr    = PA'(r_free_count - 1'b1);
                    n_free_count = r_free_count - 1'b1;
                    n_nio        = r_nio + 1'b1;
                    n_state      = S_NODE_OUT;
                end
            end
            S_NODE_OUT: begin
                n_res.granted_id = r_stk_q;
                n_res.id_valid   = 1'b1;
                n_res.last       = 1'b1;
                n_res_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            S_TICK_A: begin
                slot_re = 1'b1;
                n_state = S_TICK_B;
            end
            S_TICK_B: begin
                // retire the current slot into the totals, step the pointer
                n_req_total   = r_req_total + TW'(slot_req);
                n_rel_total   = r_rel_total + TW'(slot_rel);
                n_slot_ptr    = tick_np;
                n_window_full = r_window_full | tick_wrap;
                slot_re       = 1'b1;
                slot_raddr    = tick_np;
                n_state       = S_TICK_C;
            end
            S_TICK_C: begin
                // drop the oldest slot once the ring has filled, then clear it
                if (r_window_full) begin
                    n_req_total = r_req_total - TW'(slot_req);
                    n_rel_total = r_rel_total - TW'(slot_rel);
                end
                slot_wr.we   = 1'b1;
                slot_wr.addr = r_slot_ptr;
                n_time_moved = 1'b1;
                n_res.last   = 1'b1;
                n_res_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            S_FIN: begin
                n_res.last  = 1'b1;
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_static_gain <= 16'd256;
            r_switch_thr  <= 9'd128;
            r_win_m1      <= 6'd10;
            r_rate_gain   <= 16'd256;
            r_node_ratio  <= 9'd256;
            r_node_cap    <= CW'(1);
            r_batch_max   <= CW'(64);
            r_batch_min   <= '0;
            r_free_count  <= '0;
            r_total_ids   <= '0;
            r_nio         <= '0;
            r_node_limit  <= CW'(1);
            r_req_total   <= '0;
            r_rel_total   <= '0;
            r_slot_ptr    <= '0;
            r_window_full <= 1'b0;
            r_static_mode <= 1'b1;
            r_started     <= 1'b0;
            r_time_moved  <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_static_gain <= n_static_gain;
            r_switch_thr  <= n_switch_thr;
            r_win_m1      <= n_win_m1;
            r_rate_gain   <= n_rate_gain;
            r_node_ratio  <= n_node_ratio;
            r_node_cap    <= n_node_cap;
            r_batch_max   <= n_batch_max;
            r_batch_min   <= n_batch_min;
            r_free_count  <= n_free_count;
            r_total_ids   <= n_total_ids;
            r_nio         <= n_nio;
            r_node_limit  <= n_node_limit;
            r_req_total   <= n_req_total;
            r_rel_total   <= n_rel_total;
            r_slot_ptr    <= n_slot_ptr;
            r_window_full <= n_window_full;
            r_static_mode <= n_static_mode;
            r_started     <= n_started;
            r_time_moved  <= n_time_moved;
            r_res_valid   <= n_res_valid;
        end
        r_item <= n_item;
        r_prod <= n_prod;
        r_m    <= n_m;
        r_size <= n_size;
        r_k    <= n_k;
        r_base <= n_base;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    // config waits while an item is in flight or being offered
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;

    // an accepted item keeps the block busy the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not make the block busy");

    // the final result of an item is never directly followed by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result right after a final result");

    // only batch grants give more than one result, and they all carry ids
    a_multi_has_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> o_res.id_valid)
        else $error("non-final result without id");

    // pool fill never exceeds its depth
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CW'(rawip_pkg::POOL_DEPTH))
        else $error("free count beyond pool depth");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the rate-aware worker id pool unit
`timescale 1ns / 1ps
module tb;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_start = 1'b0;
    rawip_pkg::t_item            i_item = '0;
    logic                        o_busy;
    logic                        o_res_valid;
    rawip_pkg::t_result          o_res;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [2:0]                  i_cfg_index = '0;
    logic [rawip_pkg::CFG_W-1:0] i_cfg_data = '0;

    rate_aware_worker_id_pool_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // items waiting to be driven and grants still owed by the block
    rawip_pkg::t_item   pending_items[$];
    rawip_pkg::t_result owed_results[$];

    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned ids_granted = 0;
    int unsigned faults_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_cycles = 0;

    // shadow copy of the pool state and its registers
    logic [15:0] sh_static_gain = 16'd256;
    logic [8:0]  sh_switch_thr = 9'd128;
    logic [5:0]  sh_win_m1 = 6'd10;
    logic [15:0] sh_rate_gain = 16'd256;
    logic [8:0]  sh_node_ratio = 9'd256;
    logic [6:0]  sh_node_cap = 7'd1;
    logic [6:0]  sh_batch_max = 7'd64;
    logic [6:0]  sh_batch_min = 7'd0;

    logic [7:0]  id_stack [rawip_pkg::POOL_DEPTH];
    int unsigned free_cnt = 0, total_cnt = 0, nodes_out = 0, node_lim = 1;
    int unsigned req_slot [rawip_pkg::WINDOW_DEPTH];
    int unsigned rel_slot [rawip_pkg::WINDOW_DEPTH];
    logic [21:0] req_sum = '0, rel_sum = '0;
    int unsigned slot_ptr = 0;
    bit win_full = 0, static_md = 1, clock_run = 0, tick_seen = 0;

    initial begin
        foreach (req_slot[i]) begin
            req_slot[i] = 0;
            rel_slot[i] = 0;
        end
    end

    function automatic void owe(logic [7:0] id, logic vld, logic [6:0] cnt, logic lst,
                                logic flt);
        rawip_pkg::t_result r;
        r.granted_id = id;
        r.id_valid = vld;
        r.grant_count = cnt;
        r.last = lst;
        r.fault = flt;
        owed_results = {owed_results, r};
    endfunction

    function automatic void refresh_node_limit();
        int unsigned lim;
        lim = (sh_node_ratio * total_cnt) >> 8;
        if (lim > sh_node_cap) lim = sh_node_cap;
        if (lim == 0) lim = 1;
        node_lim = lim;
    endfunction

    // counts one request or release into the current slot; re-evaluates mode after a tick
    function automatic void count_event(int unsigned req, int unsigned rel);
        longint lhs, rhs;
        if (!clock_run) begin
            clock_run = 1;
            tick_seen = 0;
            slot_ptr = 0;
            req_slot[0] = req;
            rel_slot[0] = rel;
            return;
        end
        req_slot[slot_ptr] = (req_slot[slot_ptr] + req > 65535) ? 65535
                                                                 : req_slot[slot_ptr] + req;
        rel_slot[slot_ptr] = (rel_slot[slot_ptr] + rel > 65535) ? 65535
                                                                 : rel_slot[slot_ptr] + rel;
        if (tick_seen) begin
            lhs = longint'(free_cnt) * 256;
            rhs = (256 - longint'(sh_switch_thr)) * (longint'(total_cnt) - longint'(nodes_out));
            tick_seen = 0;
            static_md = !win_full || lhs >= rhs;
        end
    endfunction

    function automatic bit push_id(logic [7:0] id);
        if (free_cnt >= rawip_pkg::POOL_DEPTH) return 0;
        id_stack[free_cnt] = id;
        free_cnt++;
        return 1;
    endfunction

    // works out every result the block owes for one accepted item
    function automatic void predict_pool(rawip_pkg::t_item it);
        logic flt;
        longint size, num;
        int unsigned m, base, p;
        flt = 0;
        case (it.operation)
            rawip_pkg::OP_ADD: begin
                if (total_cnt >= 127 || !push_id(it.worker_id)) flt = 1;
                else begin
                    total_cnt++;
                    refresh_node_limit();
                end
                owe(0, 0, 0, 1, flt);
            end
            rawip_pkg::OP_REQ_BATCH: begin
                count_event(1, 0);
                m = 2 * nodes_out;
                if (m > node_lim) m = node_lim;
                if (static_md) begin
                    if (m == 0) size = free_cnt;
                    else begin
                        num = longint'(sh_static_gain) * (longint'(total_cnt) - longint'(m));
                        size = (num < 0) ? 0 : num / (longint'(m) * 256);
                    end
                end else if (req_sum == 0) begin
                    size = free_cnt;
                end else begin
                    size = (longint'(sh_rate_gain) * longint'(rel_sum)) /
                           (longint'(req_sum) * 256);
                end
                if (size > free_cnt) size = free_cnt;
                if (size < 0) size = 0;
                if (it.wanted >= sh_batch_min && size < sh_batch_min) size = 0;
                if (size > sh_batch_max) size = sh_batch_max;
                if (size != 0 && size[0] == 1'b0) size--;
                if (size > it.wanted) size = it.wanted;
                if (size > 64) size = 64;
                if (size == 0) owe(0, 0, 0, 1, 0);
                else begin
                    base = free_cnt - size;
                    for (int i = 0; i < size; i++)
                        owe(id_stack[base + i], 1, size[6:0], (i + 1 == size), 0);
                    free_cnt = base;
                end
            end
            rawip_pkg::OP_REL_BATCH: begin
                count_event(0, 1);
                if (!push_id(it.worker_id)) flt = 1;
                owe(0, 0, 0, 1, flt);
            end
            rawip_pkg::OP_REQ_NODE: begin
                if (free_cnt == 0 || nodes_out >= node_lim) owe(0, 0, 0, 1, 0);
                else begin
                    nodes_out++;
                    free_cnt--;
                    owe(id_stack[free_cnt], 1, 0, 1, 0);
                end
            end
            rawip_pkg::OP_REL_NODE: begin
                count_event(0, 1);
                if (!push_id(it.worker_id)) flt = 1;
                if (nodes_out == 0) flt = 1;
                else nodes_out--;
                owe(0, 0, 0, 1, flt);
            end
            rawip_pkg::OP_TICK: begin
                // ring moves one slot: current slot into the sums, the slot entered leaves
                if (clock_run) begin
                    p = slot_ptr;
                    req_sum = req_sum + req_slot[p];
                    rel_sum = rel_sum + rel_slot[p];
                    p++;
                    if (p > sh_win_m1 || p >= rawip_pkg::WINDOW_DEPTH) begin
                        p = 0;
                        win_full = 1;
                    end
                    if (win_full) begin
                        req_sum = req_sum - req_slot[p];
                        rel_sum = rel_sum - rel_slot[p];
                    end
                    req_slot[p] = 0;
                    rel_slot[p] = 0;
                    slot_ptr = p;
                    tick_seen = 1;
                end
                owe(0, 0, 0, 1, 0);
            end
            default: owe(0, 0, 0, 1, 0);
        endcase
    endfunction

    // driver: bursts of items with random gaps, item held until accepted
    int unsigned burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                predict_pool(i_item);
                void'(pending_items.pop_front());
                items_sent++;
                if (burst_left > 0) burst_left--;
            end
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_start <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: each strobed result against the oldest owed one
    always @(posedge i_clk) begin
        rawip_pkg::t_result want;
        if (i_rst_n && o_res_valid) begin
            results_seen++;
            if (o_res.id_valid) ids_granted++;
            if (o_res.fault) faults_seen++;
            if (owed_results.size() == 0) begin
                $error("unexpected result granted_id=%0d last=%0b", o_res.granted_id,
                       o_res.last);
                errors++;
            end else begin
                want = owed_results.pop_front();
                if (o_res.granted_id !== want.granted_id) begin
                    $error("granted_id: expected %0d, got %0d", want.granted_id,
                           o_res.granted_id);
                    errors++;
                end
                if (o_res.id_valid !== want.id_valid) begin
                    $error("id_valid: expected %0b, got %0b", want.id_valid, o_res.id_valid);
                    errors++;
                end
                if (o_res.grant_count !== want.grant_count) begin
                    $error("grant_count: expected %0d, got %0d", want.grant_count,
                           o_res.grant_count);
                    errors++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_res.last);
                    errors++;
                end
                if (o_res.fault !== want.fault) begin
                    $error("fault: expected %0b, got %0b", want.fault, o_res.fault);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("rate_aware_worker_id_pool_unit regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[rawip_pkg::CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            rawip_pkg::CFG_STATIC_GAIN: sh_static_gain = val[15:0];
            rawip_pkg::CFG_SWITCH_THR:  sh_switch_thr = val[8:0];
            rawip_pkg::CFG_WIN_M1:      sh_win_m1 = val[5:0];
            rawip_pkg::CFG_RATE_GAIN:   sh_rate_gain = val[15:0];
            rawip_pkg::CFG_NODE_RATIO: begin
                sh_node_ratio = val[8:0];
                refresh_node_limit();
            end
            rawip_pkg::CFG_NODE_CAP: begin
                sh_node_cap = val[6:0];
                refresh_node_limit();
            end
            rawip_pkg::CFG_BATCH_MAX:   sh_batch_max = val[6:0];
            default:                    sh_batch_min = val[6:0];
        endcase
    endtask

    task automatic cfg_all(input int unsigned sg, thr, win, rg, ratio, cap, bmax, bmin);
        cfg_write(rawip_pkg::CFG_STATIC_GAIN, sg);
        cfg_write(rawip_pkg::CFG_SWITCH_THR, thr);
        cfg_write(rawip_pkg::CFG_WIN_M1, win);
        cfg_write(rawip_pkg::CFG_RATE_GAIN, rg);
        cfg_write(rawip_pkg::CFG_NODE_RATIO, ratio);
        cfg_write(rawip_pkg::CFG_NODE_CAP, cap);
        cfg_write(rawip_pkg::CFG_BATCH_MAX, bmax);
        cfg_write(rawip_pkg::CFG_BATCH_MIN, bmin);
    endtask

    // wait until every item is taken and every result is in, then let the block settle
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || owed_results.size() != 0 || i_start || o_busy);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void queue_item(logic [2:0] op, logic [7:0] id, logic [6:0] want);
        rawip_pkg::t_item it;
        it.operation = op;
        it.worker_id = id;
        it.wanted = want;
        pending_items = {pending_items, it};
    endfunction

    // mostly adds and grants with releases and ticks mixed in, a few unknown codes
    function automatic void queue_random(int unsigned n);
        logic [2:0] op;
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 28)      op = rawip_pkg::OP_ADD;
            else if (pick < 48) op = rawip_pkg::OP_REQ_BATCH;
            else if (pick < 62) op = rawip_pkg::OP_REL_BATCH;
            else if (pick < 72) op = rawip_pkg::OP_REQ_NODE;
            else if (pick < 82) op = rawip_pkg::OP_REL_NODE;
            else if (pick < 96) op = rawip_pkg::OP_TICK;
            else                op = 3'($urandom_range(6, 7));
            queue_item(op, 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 2) == 0) ? 7'd64 : 7'($urandom_range(0, 64)));
        end
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tick before start, extreme ids, empty grants, node limit, underflow
        queue_item(rawip_pkg::OP_TICK, 8'h00, 7'd0);
        queue_item(rawip_pkg::OP_REQ_NODE, 8'h00, 7'd0);
        queue_item(rawip_pkg::OP_REQ_BATCH, 8'h00, 7'd64);
        queue_item(rawip_pkg::OP_ADD, 8'h00, 7'd0);
        queue_item(rawip_pkg::OP_ADD, 8'hFF, 7'd0);
        queue_item(rawip_pkg::OP_ADD, 8'hA5, 7'd0);
        queue_item(rawip_pkg::OP_ADD, 8'h5A, 7'd127);
        queue_item(rawip_pkg::OP_REQ_BATCH, 8'hFF, 7'd0);
        queue_item(rawip_pkg::OP_REQ_BATCH, 8'h00, 7'd64);
        queue_item(rawip_pkg::OP_REL_NODE, 8'h33, 7'd0);
        queue_item(rawip_pkg::OP_REQ_NODE, 8'h00, 7'd0);
        queue_item(rawip_pkg::OP_REQ_NODE, 8'h00, 7'd0);
        queue_item(rawip_pkg::OP_REL_NODE, 8'hCC, 7'd0);
        queue_item(rawip_pkg::OP_REL_BATCH, 8'h81, 7'd0);
        queue_item(rawip_pkg::OP_TICK, 8'h00, 7'd0);
        queue_item(rawip_pkg::OP_REQ_BATCH, 8'h00, 7'd2);
        queue_item(3'd6, 8'hFF, 7'd64);
        queue_item(3'd7, 8'h7E, 7'd1);
        queue_item(rawip_pkg::OP_REQ_BATCH, 8'h00, 7'd64);
        drain();

        // extremes one way: tiny window, no rate gain, smallest node share
        cfg_all(65535, 256, 1, 0, 0, 1, 64, 0);
        for (int i = 0; i < 68; i++)
            queue_item(rawip_pkg::OP_ADD, 8'($urandom_range(0, 255)), 7'd0);
        queue_item(rawip_pkg::OP_REL_BATCH, 8'h11, 7'd0);
        queue_random(25);
        drain();

        // extremes the other way: widest window, batch limits at their ends
        cfg_all(0, 0, 63, 65535, 256, 64, 0, 64);
        queue_random(25);
        drain();

        cfg_all($urandom_range(0, 65535), $urandom_range(0, 256), $urandom_range(1, 8),
                $urandom_range(0, 65535), $urandom_range(0, 256), $urandom_range(1, 64),
                $urandom_range(0, 64), $urandom_range(0, 8));
        queue_random(24);
        drain();

        cfg_all($urandom_range(256, 2048), $urandom_range(0, 256), $urandom_range(1, 63),
                $urandom_range(128, 1024), $urandom_range(64, 256), $urandom_range(1, 64),
                64, $urandom_range(0, 64));
        queue_random(24);
        drain();

        cfg_all(256, 128, 2, 512, 256, 16, 33, 3);
        queue_random(24);
        drain();

        $display("covered %0d items, %0d results, %0d ids granted, %0d faults",
                 items_sent, results_seen, ids_granted, faults_seen);
        $display("with %0d register writes over six register settings", cfg_writes);
        if (errors == 0)
            $display("rate_aware_worker_id_pool_unit regression: pass");
        else
            $display("rate_aware_worker_id_pool_unit regression: fail");
        $finish;
    end
endmodule
